// File: rtl/mbsep_pkg.sv
// ----------------------------------------------------------------------------
// mbsep_pkg
// Types, constants and the event decode shared by the MIDI parser files.
// ----------------------------------------------------------------------------
package mbsep_pkg;

  // status high nibbles
  localparam logic [3:0] STAT_NOTE_OFF   = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON    = 4'h9;
  localparam logic [3:0] STAT_AFTERTOUCH = 4'hA;
  localparam logic [3:0] STAT_CTRL_CHG   = 4'hB;
  localparam logic [3:0] STAT_PROG_CHG   = 4'hC;
  localparam logic [3:0] STAT_CHAN_PRESS = 4'hD;
  localparam logic [3:0] STAT_PITCH_BEND = 4'hE;
  localparam logic [3:0] STAT_SYSTEM     = 4'hF;

  localparam logic [1:0] DUE_NONE = 2'd0;
  localparam logic [1:0] DUE_ONE  = 2'd1;
  localparam logic [1:0] DUE_TWO  = 2'd2;

  typedef enum logic [2:0] {
    EVT_NONE        = 3'd0,
    EVT_NOTE_OFF    = 3'd1,
    EVT_NOTE_ON     = 3'd2,
    EVT_AFTERTOUCH  = 3'd3,
    EVT_CTRL_CHG    = 3'd4,
    EVT_CHAN_PRESS  = 3'd5,
    EVT_PITCH_BEND  = 3'd6
  } evt_type_e;

  typedef struct packed {
    logic [2:0] event_type;
    logic [3:0] channel;
    logic [7:0] note;
    logic [7:0] value;
  } evt_t;

  // input stage handed to the parser core
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  function automatic logic one_data_byte(input logic [7:0] st);
    return (st[7:4] == STAT_PROG_CHG) || (st[7:4] == STAT_CHAN_PRESS);
  endfunction

  function automatic evt_t decode_event(input logic [7:0] st,
                                        input logic [7:0] d1,
                                        input logic [7:0] d2);
    evt_t e;
    e.event_type = EVT_NONE;
    e.channel    = st[3:0];
    e.note       = 8'd0;
    e.value      = 8'd0;
    case (st[7:4])
      STAT_NOTE_OFF: begin
        e.event_type = EVT_NOTE_OFF;
        e.note       = d1;
      end
      STAT_NOTE_ON: begin
        e.event_type = (d2 != 8'd0) ? EVT_NOTE_ON : EVT_NOTE_OFF;
        e.note       = d1;
        e.value      = d2;
      end
      STAT_AFTERTOUCH: begin
        e.event_type = EVT_AFTERTOUCH;
        e.note       = d1;
        e.value      = d2;
      end
      STAT_CTRL_CHG: begin
        e.event_type = EVT_CTRL_CHG;
        e.note       = d1;
        e.value      = d2;
      end
      STAT_CHAN_PRESS: begin
        e.event_type = EVT_CHAN_PRESS;
        e.value      = d1;
      end
      STAT_PITCH_BEND: begin
        e.event_type = EVT_PITCH_BEND;
        e.value      = d2;
      end
      default: begin
        e.event_type = EVT_NONE;
        e.channel    = 4'd0;
      end
    endcase
    return e;
  endfunction

endpackage

// File: rtl/mbsep_byte_if.sv
// ----------------------------------------------------------------------------
// mbsep_byte_if
// Request channel carrying one received MIDI byte.
// ----------------------------------------------------------------------------
interface mbsep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: rtl/mbsep_evt_if.sv
// ----------------------------------------------------------------------------
// mbsep_evt_if
// Request channel carrying one decoded MIDI event.
// ----------------------------------------------------------------------------
interface mbsep_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_type;
  logic [3:0] channel;
  logic [7:0] note;
  logic [7:0] value;

  modport source (output valid, output event_type, output channel,
                  output note, output value, input ready);
  modport sink   (input valid, input event_type, input channel,
                  input note, input value, output ready);
endinterface

// File: rtl/mbsep_in_reg.sv
// ----------------------------------------------------------------------------
// mbsep_in_reg
// Input register: holds one byte until the parser core consumes it.
// ----------------------------------------------------------------------------
module mbsep_in_reg import mbsep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  output stage_t     stage_o,
  input  logic       advance_i
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= byte_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

// File: rtl/mbsep_core.sv
// ----------------------------------------------------------------------------
// mbsep_core
// Running-status parser state and the registered event output.
// ----------------------------------------------------------------------------
module mbsep_core import mbsep_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t stage_i,
  output logic   advance_o,
  output logic   evt_valid_o,
  output evt_t   evt_o,
  input  logic   evt_ready_i
);

  logic [7:0] last_status_q, last_status_d;
  logic [1:0] bytes_due_q, bytes_due_d;
  logic [7:0] first_data_q, first_data_d;
  logic       evt_valid_q, evt_valid_d;
  evt_t       evt_q;

  logic [7:0] b;
  logic       has_res;
  logic       run_one;
  evt_t       evt_new;

  assign b       = stage_i.data;
  assign run_one = one_data_byte(last_status_q);

  // d1 comes from the stored byte only for two-byte messages
  assign evt_new = decode_event(last_status_q, run_one ? b : first_data_q, b);

  always_comb begin
    last_status_d = last_status_q;
    bytes_due_d   = bytes_due_q;
    first_data_d  = first_data_q;
    has_res       = 1'b0;
    if (b[7:4] != STAT_SYSTEM) begin
      case (bytes_due_q)
        DUE_NONE: begin
          if (b[7]) begin
            last_status_d = b;
            bytes_due_d   = one_data_byte(b) ? DUE_ONE : DUE_TWO;
          end else if (run_one) begin
            has_res = 1'b1;
          end else begin
            first_data_d = b;
            bytes_due_d  = DUE_ONE;
          end
        end
        DUE_TWO: begin
          first_data_d = b;
          bytes_due_d  = DUE_ONE;
        end
        default: begin
          bytes_due_d = DUE_NONE;
          has_res     = 1'b1;
        end
      endcase
    end
  end

  // bytes that complete nothing pass even while a result waits
  assign advance_o = stage_i.valid && (!has_res || !evt_valid_q || evt_ready_i);

  always_comb begin
    evt_valid_d = evt_valid_q;
    if (advance_o && has_res) begin
      evt_valid_d = 1'b1;
    end else if (evt_ready_i) begin
      evt_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_status_q <= 8'd0;
      bytes_due_q   <= DUE_NONE;
      evt_valid_q   <= 1'b0;
    end else begin
      evt_valid_q <= evt_valid_d;
      if (advance_o) begin
        last_status_q <= last_status_d;
        bytes_due_q   <= bytes_due_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      first_data_q <= first_data_d;
    end
    if (advance_o && has_res) begin
      evt_q <= evt_new;
    end
  end

  assign evt_valid_o = evt_valid_q;
  assign evt_o       = evt_q;

endmodule

// File: rtl/midi_byte_stream_event_parser_unit.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_event_parser_unit
// MIDI byte stream to channel event parser with running status.
// ----------------------------------------------------------------------------
// Takes one MIDI byte per cycle, unless a completing byte is held, and emits one
// event per complete channel message; system bytes (0xF0 and up) are dropped.
// A byte is captured in the input register when it is accepted and goes
// through the parser into the event register once the core advances it.
// While an event waits on the output, bytes that complete nothing keep
// flowing; only a completing byte holds in the input register until the
// output register frees.
module midi_byte_stream_event_parser_unit import mbsep_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mbsep_byte_if.sink   byte_i,
  mbsep_evt_if.source  event_o
);

  stage_t stage;
  logic   advance;
  logic   evt_valid;
  evt_t   evt;

  mbsep_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (byte_i.valid),
    .byte_i    (byte_i.in_byte),
    .ready_o   (byte_i.ready),
    .stage_o   (stage),
    .advance_i (advance)
  );

  mbsep_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .advance_o   (advance),
    .evt_valid_o (evt_valid),
    .evt_o       (evt),
    .evt_ready_i (event_o.ready)
  );

  assign event_o.valid      = evt_valid;
  assign event_o.event_type = evt.event_type;
  assign event_o.channel    = evt.channel;
  assign event_o.note       = evt.note;
  assign event_o.value      = evt.value;

endmodule

// File: bench/mbsep_event_checker.sv
// ----------------------------------------------------------------------------
// mbsep_event_checker
// Watches the byte and event channels, predicts each MIDI event from the
// accepted bytes with its own running-status parser, and compares every
// accepted event field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mbsep_event_checker
  import mbsep_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic       byte_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       evt_valid_i,
  input  logic       evt_ready_i,
  input  logic [2:0] evt_type_i,
  input  logic [3:0] evt_channel_i,
  input  logic [7:0] evt_note_i,
  input  logic [7:0] evt_value_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser state as seen by the predictor
  logic [7:0] run_status;
  logic [1:0] data_left;
  logic [7:0] held_data;

  evt_t due_events [$];
  int   fails;
  int   checked;

  function automatic logic is_single_data(input logic [7:0] st);
    return (st[7:4] == STAT_PROG_CHG) || (st[7:4] == STAT_CHAN_PRESS);
  endfunction

  function automatic evt_t make_event(input logic [7:0] st, input logic [7:0] d1,
                                      input logic [7:0] d2);
    evt_t e;
    e.event_type = EVT_NONE;
    e.channel    = st[3:0];
    e.note       = 8'd0;
    e.value      = 8'd0;
    case (st[7:4])
      STAT_NOTE_OFF: begin
        e.event_type = EVT_NOTE_OFF;
        e.note       = d1;
      end
      STAT_NOTE_ON: begin
        // zero velocity reads as a release
        e.event_type = (d2 == 8'd0) ? EVT_NOTE_OFF : EVT_NOTE_ON;
        e.note       = d1;
        e.value      = d2;
      end
      STAT_AFTERTOUCH: begin
        e.event_type = EVT_AFTERTOUCH;
        e.note       = d1;
        e.value      = d2;
      end
      STAT_CTRL_CHG: begin
        e.event_type = EVT_CTRL_CHG;
        e.note       = d1;
        e.value      = d2;
      end
      STAT_CHAN_PRESS: begin
        e.event_type = EVT_CHAN_PRESS;
        e.value      = d1;
      end
      STAT_PITCH_BEND: begin
        e.event_type = EVT_PITCH_BEND;
        e.value      = d2;
      end
      default: begin
        // program change and the power-up status of zero
        e.channel = 4'd0;
      end
    endcase
    return e;
  endfunction

  task automatic parse_midi_byte(input logic [7:0] b);
    if (b[7:4] == STAT_SYSTEM) return;
    if (data_left == DUE_NONE) begin
      if (b[7]) begin
        run_status = b;
        data_left  = is_single_data(b) ? DUE_ONE : DUE_TWO;
      end else if (is_single_data(run_status)) begin
        due_events.push_back(make_event(run_status, b, 8'd0));
      end else begin
        held_data = b;
        data_left = DUE_ONE;
      end
    end else if (data_left == DUE_TWO) begin
      // any non-system byte counts as data here, status bytes too
      held_data = b;
      data_left = DUE_ONE;
    end else begin
      data_left = DUE_NONE;
      if (is_single_data(run_status)) begin
        due_events.push_back(make_event(run_status, b, 8'd0));
      end else begin
        due_events.push_back(make_event(run_status, held_data, b));
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    evt_t want;
    if (!rst_ni) begin
      run_status = 8'h00;
      data_left  = DUE_NONE;
      held_data  = 8'h00;
      due_events.delete();
      fails   = 0;
      checked = 0;
    end else begin
      // compare first: a byte taken at this edge cannot cause this event
      if (evt_valid_i && evt_ready_i) begin
        if (due_events.size() == 0) begin
          fails++;
          $error("unexpected event: type %0d channel %0d note %0d value %0d",
                 evt_type_i, evt_channel_i, evt_note_i, evt_value_i);
        end else begin
          want = due_events.pop_front();
          checked++;
          check_field("event_type", int'(want.event_type), int'(evt_type_i));
          check_field("channel", int'(want.channel), int'(evt_channel_i));
          check_field("note", int'(want.note), int'(evt_note_i));
          check_field("value", int'(want.value), int'(evt_value_i));
        end
      end
      if (byte_valid_i && byte_ready_i) parse_midi_byte(in_byte_i);
    end
    fail_count_o <= fails;
    pending_o    <= due_events.size();
    checked_o    <= checked;
  end

endmodule

// File: bench/tb_midi_byte_stream_event_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_midi_byte_stream_event_parser_unit
// Drives directed and random MIDI byte streams into the parser under three
// idling mixes and one long output stall; the checker scores the events.
// ----------------------------------------------------------------------------
module tb_midi_byte_stream_event_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mbsep_pkg::*;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 300;

  logic clk_i;
  logic rst_ni;
  int   phase;
  int   fail_count;
  int   pending;
  int   checked;
  int   data_total;
  int   system_total;
  logic [7:0] stim_status;

  // directed opening: power-up status, every message kind, running status,
  // zero velocity, system bytes inside a message, status bytes as data
  logic [7:0] directed_bytes [$] = '{
    8'h00, 8'h7F, 8'hF8,
    8'h90, 8'h3C, 8'h40, 8'h3C, 8'h00,
    8'h8F, 8'h7F, 8'h7F,
    8'hA5, 8'h10, 8'h20,
    8'hB3, 8'h07, 8'hFE, 8'h7F,
    8'hC2, 8'h05, 8'h06,
    8'hDE, 8'h55,
    8'hE1, 8'h00, 8'h7F,
    8'h90, 8'h80, 8'hEF,
    8'hF0, 8'hFF
  };

  mbsep_byte_if byte_if();
  mbsep_evt_if  evt_if();

  midi_byte_stream_event_parser_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .event_o (evt_if)
  );

  mbsep_event_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_if.valid),
    .byte_ready_i  (byte_if.ready),
    .in_byte_i     (byte_if.in_byte),
    .evt_valid_i   (evt_if.valid),
    .evt_ready_i   (evt_if.ready),
    .evt_type_i    (evt_if.event_type),
    .evt_channel_i (evt_if.channel),
    .evt_note_i    (evt_if.note),
    .evt_value_i   (evt_if.value),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int send_idle_pct(input int ph);
    return (ph == 0) ? 10 : (ph == 1) ? 59 : 0;
  endfunction

  function automatic int recv_idle_pct(input int ph);
    return (ph == 0) ? 59 : (ph == 1) ? 10 : 0;
  endfunction

  // called right after an edge; holds the request until it is taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct(phase)) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= b;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    if (b[7:4] == STAT_SYSTEM) system_total++;
    else data_total++;
  endtask

  task automatic send_payload(input logic [7:0] b);
    logic [7:0] sys;
    if ($urandom_range(99) < 6) begin
      sys = 8'hF0 | 8'($urandom_range(15));
      send_byte(sys);
    end
    send_byte(b);
  endtask

  task automatic send_message();
    int n;
    int pick;
    logic [7:0] d;
    if (stim_status == 8'h00 || $urandom_range(99) < 60) begin
      stim_status = 8'h80 + 8'($urandom_range(111));
      send_payload(stim_status);
    end
    n = ((stim_status[7:4] == STAT_PROG_CHG) || (stim_status[7:4] == STAT_CHAN_PRESS)) ? 1 : 2;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(9);
      d = (pick == 0) ? 8'h00 : (pick == 1) ? 8'h7F : 8'($urandom_range(127));
      send_payload(d);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(3, 1);
    for (int k = 0; k < n; k++) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int start_total;
    rst_ni          = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.in_byte = 8'h00;
    phase           = 0;
    data_total      = 0;
    system_total    = 0;
    stim_status     = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    start_total = data_total;
    while (data_total - start_total < RANDOM_ITEMS) begin
      phase <= ((data_total - start_total) * 3) / RANDOM_ITEMS;
      if ($urandom_range(99) < 8) send_noise();
      else send_message();
    end
    byte_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run sent %0d parsed and %0d system bytes, checked %0d events",
             data_total, system_total, checked);
    $display("Idling mixes: sender-heavy, receiver-heavy, none; one %0d-cycle output stall",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // event side: random ready, plus one long hold when the last phase starts
  initial begin
    int hold_left;
    int last_phase;
    hold_left     = 0;
    last_phase    = 0;
    evt_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase == 2 && last_phase != 2) hold_left = HOLD_CYCLES;
      last_phase = phase;
      if (hold_left > 0) begin
        hold_left--;
        evt_if.ready <= 1'b0;
      end else begin
        evt_if.ready <= ($urandom_range(99) >= recv_idle_pct(phase));
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (evt_if.valid && evt_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/mbsep_pkg.sv
rtl/mbsep_byte_if.sv
rtl/mbsep_evt_if.sv
rtl/mbsep_in_reg.sv
rtl/mbsep_core.sv
rtl/midi_byte_stream_event_parser_unit.sv
bench/mbsep_event_checker.sv
bench/tb_midi_byte_stream_event_parser_unit.sv
